FILE: rtl/multicart_outer_bank_mapper_macros.svh
// assertion macros for the multicart outer bank mapper
`ifndef MULTICART_OUTER_BANK_MAPPER_MACROS_SVH
`define MULTICART_OUTER_BANK_MAPPER_MACROS_SVH

// condition that must hold at every clock edge outside reset
`define MCOBM_ASSERT_NOW(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("mcobm: immediate check failed");

// consequent must hold in the cycle after the antecedent
`define MCOBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mcobm: next-cycle check failed");

`endif

FILE: rtl/mcobm_pkg.sv
// shared types and constants for the multicart outer bank mapper
`default_nettype none

package mcobm_pkg;

  typedef enum logic [1:0] {
    OP_CPU_WRITE = 2'd0,
    OP_PRG_QUERY = 2'd1,
    OP_CHR_QUERY = 2'd2
  } op_t;

  // configuration register indexes
  localparam logic [1:0] CFG_WINDOW_AT_5000  = 2'd0;
  localparam logic [1:0] CFG_BOARD_VARIANT   = 2'd1;
  localparam logic [1:0] CFG_PRG_HALF_BANKS  = 2'd2;
  localparam logic [1:0] CFG_CHR_RAM_PRESENT = 2'd3;

  localparam int unsigned CfgDataW = 12;

  // outer register indexes with special meaning
  localparam logic [2:0] OREG_CHR_OUTER = 3'd2;
  localparam logic [2:0] OREG_CONTROL   = 3'd3;

  // board variant codes (bit 0 dropped)
  localparam logic [2:0] VAR_LAYOUT_2 = 3'd1;
  localparam logic [2:0] VAR_LAYOUT_4 = 3'd2;
  localparam logic [2:0] VAR_LAYOUT_6 = 3'd3;
  localparam logic [2:0] VAR_LAYOUT_8 = 3'd4;

  localparam logic [15:0] PRG_FIXED_C000 = 16'hC000;
  localparam logic [15:0] PRG_FIXED_E000 = 16'hE000;
  localparam logic [15:0] CHR_SLOT_0000  = 16'h0000;
  localparam logic [15:0] CHR_SLOT_0400  = 16'h0400;
  localparam logic [15:0] CHR_SLOT_0800  = 16'h0800;
  localparam logic [15:0] CHR_SLOT_0C00  = 16'h0C00;

  localparam logic [11:0] PRG_HALF_BANKS_RST = 12'd64;

  typedef logic [7:0][7:0] outer_regs_t;

  typedef struct packed {
    logic        window_at_5000;
    logic [3:0]  board_variant;
    logic [11:0] prg_half_banks;
    logic        chr_ram_present;
  } cfg_t;

  typedef struct packed {
    logic written;
    logic forward;
  } wr_status_t;

  typedef struct packed {
    logic [11:0] bank;
    logic        use_chr_ram;
    logic        chr_write_enable;
    logic        forward_to_inner;
    logic        register_written;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/mcobm_regs.sv
// outer register file with window decode and lock handling
`default_nettype none

module mcobm_regs (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 commit,
  input  wire logic [15:0]          address,
  input  wire logic [7:0]           value,
  input  wire logic                 window_at_5000,
  output mcobm_pkg::outer_regs_t    regs,
  output mcobm_pkg::wr_status_t     status
);
  import mcobm_pkg::*;

  logic       in_window;
  logic [2:0] idx;
  logic       allowed;
  logic [7:0] r2;
  logic [7:0] r2_val;
  logic [7:0] wr_val;

  assign idx = address[2:0];
  assign r2  = regs[OREG_CHR_OUTER];

  always_comb begin
    if (window_at_5000) begin
      in_window = (address[15:12] == 4'h5);
    end else begin
      in_window = (address[15:13] == 3'b011);
    end
  end

  assign allowed = !regs[OREG_CONTROL][7] || (idx == OREG_CHR_OUTER);

  // partial lock on register 2: upper nibble held, bits 3..1 maskable
  always_comb begin
    r2_val = r2[7] ? {r2[7:4], value[3:0]} : value;
    r2_val = r2_val & {4'hF, ~r2[6:4], 1'b1};
    wr_val = (idx == OREG_CHR_OUTER) ? r2_val : value;
  end

  assign status.written = in_window && allowed;
  assign status.forward = !in_window && address[15];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (commit && status.written) begin
      regs[idx] <= wr_val;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mcobm_bank_calc.sv
// prg and chr bank arithmetic from the outer registers
`default_nettype none

module mcobm_bank_calc (
  input  wire logic [1:0]            operation,
  input  wire logic [15:0]           address,
  input  wire logic [7:0]            value,
  input  wire logic [7:0]            inner_mode,
  input  wire logic [7:0]            inner_bank0,
  input  wire logic [7:0]            inner_bank1,
  input  wire logic [7:0]            inner_bank2,
  input  wire mcobm_pkg::outer_regs_t regs,
  input  wire mcobm_pkg::cfg_t        cfg,
  output mcobm_pkg::res_t             res
);
  import mcobm_pkg::*;

  logic [7:0]  r0, r1, r2, r3, r4;
  logic [2:0]  var_code;

  logic [7:0]  p_mm;
  logic [1:0]  p_mg;
  logic [11:0] p_off;
  logic [11:0] p_moff;
  logic        p_chip;
  logic [11:0] p_bank;

  logic [7:0]  c_mm;
  logic [2:0]  c_mg;
  logic [11:0] c_off;
  logic [11:0] c_moff;
  logic [15:0] c_addr;
  logic [7:0]  c_val;
  logic [2:0]  c_slot;
  logic        c_ram;
  logic        c_we;
  logic [11:0] c_bank;

  assign r0 = regs[0];
  assign r1 = regs[1];
  assign r2 = regs[2];
  assign r3 = regs[3];
  assign r4 = regs[4];
  assign var_code = cfg.board_variant[3:1];

  // prg side
  assign p_mm = {r1[5], r1[6], ~r1[7], ~r0[6], {4{~r3[4]}}};

  always_comb begin
    p_chip = r0[7] ? r0[3] : (inner_mode[7] ? inner_bank2[7] : inner_bank0[7]);
    if (var_code == VAR_LAYOUT_2) begin
      p_mg  = r3[4] ? (r1[4] ? 2'd1 : 2'd3) : 2'd0;
      p_off = {r0[5:4], r1[1], r1[2], r1[3], r0[2:0], r3[3:1], 1'b0};
    end else if (var_code == VAR_LAYOUT_4) begin
      p_mg  = r3[4] ? (r1[1] ? 2'd3 : 2'd1) : 2'd0;
      p_off = {3'b000, r0[5:4], r0[2:0], r3[3:1], 1'b0};
    end else begin
      p_mg  = r3[4] ? (r1[1] ? 2'd3 : 2'd1) : 2'd0;
      p_off = {r0[5:4], r1[3:2], r1[4], r0[2:0], r3[3:1], 1'b0};
      if (var_code == VAR_LAYOUT_6) begin
        p_off = p_off & (cfg.prg_half_banks - 12'd1);
        if (p_chip) begin
          p_off = p_off | cfg.prg_half_banks;
        end
      end
    end
    p_moff = p_off & ~({4'b0000, p_mm} | {10'd0, p_mg});

    if (r3[6]) begin
      if (inner_mode[6]) begin
        p_bank = '0;
      end else if (address == PRG_FIXED_C000) begin
        p_bank = p_moff | {10'd0, p_mg[1], 1'b0};
      end else if (address == PRG_FIXED_E000) begin
        p_bank = p_moff | {10'd0, p_mg};
      end else begin
        p_bank = '0;
      end
    end else begin
      p_bank = {4'b0000, value & p_mm} | p_moff | {10'd0, address[14:13] & p_mg};
    end
  end

  // chr side
  always_comb begin
    c_mm  = r3[4] ? 8'h00 : (r0[7] ? 8'h7F : 8'hFF);
    c_mg  = r3[4] ? 3'd7 : 3'd0;
    c_we  = !((var_code == VAR_LAYOUT_8) && r0[4]);
    c_off = {4'b0000, r0[3], r2[3:0], 3'b000};
    if (var_code == VAR_LAYOUT_4) begin
      c_off = c_off | {r0[5:4], r0[2:1], 8'h00};
    end else begin
      c_off = c_off | {2'b00, r0[5:4], 8'h00};
    end
    c_moff = c_off & ~({4'b0000, c_mm} | {9'd0, c_mg});

    c_addr = address ^ {3'b000, inner_mode[7], 12'h000};
    c_val  = value;
    if (r3[6]) begin
      if (c_addr == CHR_SLOT_0000) begin
        c_val = inner_bank0;
      end else if (c_addr == CHR_SLOT_0800) begin
        c_val = inner_bank1;
      end else if (c_addr == CHR_SLOT_0400 || c_addr == CHR_SLOT_0C00) begin
        c_val = 8'h00;
      end
      c_slot = {1'b0, address[11:10]};
      c_ram  = cfg.chr_ram_present;
    end else begin
      c_slot = address[12:10];
      c_ram  = r4[0] && (value[7:1] == r4[7:1]) && cfg.chr_ram_present;
    end
    c_bank = {4'b0000, c_val & c_mm} | c_moff | {9'd0, c_slot & c_mg};
  end

  always_comb begin
    res = '0;
    unique case (operation)
      OP_PRG_QUERY: begin
        res.bank = p_bank;
      end
      OP_CHR_QUERY: begin
        res.bank             = c_bank;
        res.use_chr_ram      = c_ram;
        res.chr_write_enable = c_we;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/multicart_outer_bank_mapper.sv
// top level of the multicart outer bank mapper
`default_nettype none

// Outer bank logic for a multicart built around an mmc3-style inner mapper.
// Each request is a cpu write, a prg bank query or a chr bank query, and each
// gives exactly one result. A request is taken into an input register, worked
// out by the outer register file and the bank arithmetic in one pass, and the
// result lands in a result register, from which it is offered; one request is
// accepted every cycle as long as the result side keeps taking. The input
// register and the result register are the only buffers: a stall on the result
// side holds the result register, the input register still takes one more
// request, and once both are full req_stall rises. Outer register writes take
// effect as the write leaves the input register, so a query right behind a
// write already sees the new value.
// Configuration (window, board variant, prg size, chr ram) is written through
// cfg_write / cfg_index / cfg_data and should only change while idle.

module multicart_outer_bank_mapper (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  value,
  input  wire logic [7:0]  inner_mode,
  input  wire logic [7:0]  inner_bank0,
  input  wire logic [7:0]  inner_bank1,
  input  wire logic [7:0]  inner_bank2,
  // result channel
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [11:0]      bank,
  output logic             use_chr_ram,
  output logic             chr_write_enable,
  output logic             forward_to_inner,
  output logic             register_written,
  // configuration write port
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);
  import mcobm_pkg::*;

  `include "multicart_outer_bank_mapper_macros.svh"

  cfg_t        cfg;

  // input register
  logic        s1_valid;
  logic [1:0]  s1_operation;
  logic [15:0] s1_address;
  logic [7:0]  s1_value;
  logic [7:0]  s1_inner_mode;
  logic [7:0]  s1_inner_bank0;
  logic [7:0]  s1_inner_bank1;
  logic [7:0]  s1_inner_bank2;

  logic        advance;
  logic        s1_is_write;
  logic        commit;

  outer_regs_t regs;
  wr_status_t  wr_status;
  res_t        calc_res;
  res_t        res_next;
  res_t        res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_at_5000  <= 1'b0;
      cfg.board_variant   <= 4'd0;
      cfg.prg_half_banks  <= PRG_HALF_BANKS_RST;
      cfg.chr_ram_present <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WINDOW_AT_5000:  cfg.window_at_5000  <= cfg_data[0];
        CFG_BOARD_VARIANT:   cfg.board_variant   <= cfg_data[3:0];
        CFG_PRG_HALF_BANKS:  cfg.prg_half_banks  <= cfg_data[CfgDataW-1:0];
        CFG_CHR_RAM_PRESENT: cfg.chr_ram_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // the pipe moves whenever the result register is free or being taken
  assign advance   = !res_valid || !res_stall;
  // the input register takes a request when empty or when it is moving on
  assign req_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      s1_operation   <= operation;
      s1_address     <= address;
      s1_value       <= value;
      s1_inner_mode  <= inner_mode;
      s1_inner_bank0 <= inner_bank0;
      s1_inner_bank1 <= inner_bank1;
      s1_inner_bank2 <= inner_bank2;
    end
  end

  assign s1_is_write = s1_valid && (op_t'(s1_operation) == OP_CPU_WRITE);
  assign commit      = s1_is_write && advance;

  mcobm_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .commit         (commit),
    .address        (s1_address),
    .value          (s1_value),
    .window_at_5000 (cfg.window_at_5000),
    .regs           (regs),
    .status         (wr_status)
  );

  mcobm_bank_calc u_calc (
    .operation   (s1_operation),
    .address     (s1_address),
    .value       (s1_value),
    .inner_mode  (s1_inner_mode),
    .inner_bank0 (s1_inner_bank0),
    .inner_bank1 (s1_inner_bank1),
    .inner_bank2 (s1_inner_bank2),
    .regs        (regs),
    .cfg         (cfg),
    .res         (calc_res)
  );

  // write flags only mean something for a cpu write
  always_comb begin
    res_next = calc_res;
    if (op_t'(s1_operation) == OP_CPU_WRITE) begin
      res_next.forward_to_inner = wr_status.forward;
      res_next.register_written = wr_status.written;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      res <= res_next;
    end
  end

  assign bank             = res.bank;
  assign use_chr_ram      = res.use_chr_ram;
  assign chr_write_enable = res.chr_write_enable;
  assign forward_to_inner = res.forward_to_inner;
  assign register_written = res.register_written;

  // a stall on the request side only ever comes from a full input register
  `MCOBM_ASSERT_NOW(a_stall_needs_item, !req_stall || s1_valid)
  // under the lock only register 2 may be written
  `MCOBM_ASSERT_NOW(a_lock_respected,
    !(commit && wr_status.written && regs[OREG_CONTROL][7]) ||
    (s1_address[2:0] == OREG_CHR_OUTER))
  // register 2 only changes through a committed write to it
  `MCOBM_ASSERT_NEXT(a_r2_hold,
    !(commit && wr_status.written && (s1_address[2:0] == OREG_CHR_OUTER)),
    $stable(regs[OREG_CHR_OUTER]))
  // a cpu write never produces a bank or chr flags
  `MCOBM_ASSERT_NOW(a_write_no_bank,
    !s1_is_write || (calc_res.bank == 12'd0 && !calc_res.use_chr_ram &&
    !calc_res.chr_write_enable))

endmodule

`default_nettype wire

FILE: tb/sv/multicart_outer_bank_mapper_checker.sv
`timescale 1ns / 100ps
// request/result monitor with bank prediction for the multicart outer bank mapper

module multicart_outer_bank_mapper_checker
  import mcobm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] address,
  input  logic [7:0]  value,
  input  logic [7:0]  inner_mode,
  input  logic [7:0]  inner_bank0,
  input  logic [7:0]  inner_bank1,
  input  logic [7:0]  inner_bank2,
  input  logic        res_valid,
  input  logic        res_stall,
  input  logic [11:0] bank,
  input  logic        use_chr_ram,
  input  logic        chr_write_enable,
  input  logic        forward_to_inner,
  input  logic        register_written,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  localparam logic [2:0]  OREG_OUTER_A = 3'd0;
  localparam logic [2:0]  OREG_OUTER_B = 3'd1;
  localparam logic [2:0]  OREG_CHR_RAM = 3'd4;
  localparam logic [15:0] WIN_5000_LO  = 16'h5000;
  localparam logic [15:0] WIN_5000_HI  = 16'h5FFF;
  localparam logic [15:0] WIN_6000_LO  = 16'h6000;
  localparam logic [15:0] WIN_6000_HI  = 16'h7FFF;
  localparam logic [15:0] INNER_BASE   = 16'h8000;

  outer_regs_t oregs;
  cfg_t        cfg;
  res_t        expected_results [$];
  int unsigned fail_total;

  // window write with the lock and the partial lock of the chr outer register
  function automatic res_t cpu_write_outcome(logic [15:0] addr, logic [7:0] val);
    logic [2:0] idx;
    logic [7:0] r2;
    logic [7:0] data;
    logic       hit;
    res_t       r;
    r = '0;
    idx = addr[2:0];
    data = val;
    if (cfg.window_at_5000) hit = addr >= WIN_5000_LO && addr <= WIN_5000_HI;
    else hit = addr >= WIN_6000_LO && addr <= WIN_6000_HI;
    if (hit) begin
      if (!oregs[OREG_CONTROL][7] || idx == OREG_CHR_OUTER) begin
        if (idx == OREG_CHR_OUTER) begin
          r2 = oregs[OREG_CHR_OUTER];
          if (r2[7]) data = {r2[7:4], data[3:0]};
          data &= {4'hF, ~r2[6:4], 1'b1};
        end
        oregs[idx] = data;
        r.register_written = 1'b1;
      end
    end else if (addr >= INNER_BASE) begin
      r.forward_to_inner = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [11:0] prg_bank_of(logic [15:0] addr, logic [7:0] val,
                                              logic [7:0] mode, logic [7:0] ib0,
                                              logic [7:0] ib2);
    logic [7:0]  r0, r1, r3;
    logic [11:0] mm, mg, off, moff;
    logic [2:0]  layout;
    logic        chip;
    r0 = oregs[OREG_OUTER_A];
    r1 = oregs[OREG_OUTER_B];
    r3 = oregs[OREG_CONTROL];
    layout = cfg.board_variant[3:1];
    mm = {4'd0, r1[5], r1[6], ~r1[7], ~r0[6], {4{~r3[4]}}};
    if (layout == VAR_LAYOUT_2) begin
      mg = r3[4] ? (r1[4] ? 12'd1 : 12'd3) : 12'd0;
      off = {r0[5:4], r1[1], r1[2], r1[3], r0[2:0], r3[3:1], 1'b0};
    end else if (layout == VAR_LAYOUT_4) begin
      mg = r3[4] ? (r1[1] ? 12'd3 : 12'd1) : 12'd0;
      off = {3'd0, r0[5:4], r0[2:0], r3[3:1], 1'b0};
    end else begin
      mg = r3[4] ? (r1[1] ? 12'd3 : 12'd1) : 12'd0;
      off = {r0[5:4], r1[3:2], r1[4], r0[2:0], r3[3:1], 1'b0};
      if (layout == VAR_LAYOUT_6) begin
        // outer offset folded into the chip size, chip select on top
        off &= cfg.prg_half_banks - 12'd1;
        if (r0[7]) chip = r0[3];
        else chip = mode[7] ? ib2[7] : ib0[7];
        if (chip) off |= cfg.prg_half_banks;
      end
    end
    moff = off & ~(mm | mg);
    if (r3[6]) begin
      // fixed-slot mode: only the two top slots map, and only in one inner mode
      if (mode[6]) return 12'd0;
      if (addr == PRG_FIXED_C000) return moff | (mg & 12'd2);
      if (addr == PRG_FIXED_E000) return moff | (mg & 12'd3);
      return 12'd0;
    end
    return ({4'd0, val} & mm) | moff | ({10'd0, addr[14:13]} & mg);
  endfunction

  function automatic res_t chr_lookup(logic [15:0] addr, logic [7:0] val,
                                      logic [7:0] mode, logic [7:0] ib0,
                                      logic [7:0] ib1);
    logic [7:0]  r0, r2, r3, r4, mm, pick;
    logic [11:0] off, mg, moff;
    logic [15:0] flipped;
    logic [2:0]  slot;
    res_t        r;
    r0 = oregs[OREG_OUTER_A];
    r2 = oregs[OREG_CHR_OUTER];
    r3 = oregs[OREG_CONTROL];
    r4 = oregs[OREG_CHR_RAM];
    r = '0;
    mm = r3[4] ? 8'h00 : (r0[7] ? 8'h7F : 8'hFF);
    off = {4'd0, r0[3], r2[3:0], 3'd0};
    if (cfg.board_variant[3:1] == VAR_LAYOUT_4) off |= {r0[5:4], r0[2:1], 8'd0};
    else off |= {2'd0, r0[5:4], 8'd0};
    mg = r3[4] ? 12'd7 : 12'd0;
    moff = off & ~({4'd0, mm} | mg);
    pick = val;
    if (r3[6]) begin
      // the inner bank registers stand in for the first slots of each half
      flipped = addr ^ {3'd0, mode[7], 12'd0};
      if (flipped == CHR_SLOT_0000) pick = ib0;
      else if (flipped == CHR_SLOT_0800) pick = ib1;
      else if (flipped == CHR_SLOT_0400 || flipped == CHR_SLOT_0C00) pick = 8'd0;
      slot = {1'b0, addr[11:10]};
      r.use_chr_ram = cfg.chr_ram_present;
    end else begin
      slot = addr[12:10];
      r.use_chr_ram = r4[0] && (val[7:1] == r4[7:1]) && cfg.chr_ram_present;
    end
    r.bank = {4'd0, pick & mm} | moff | ({9'd0, slot} & mg);
    r.chr_write_enable = !(cfg.board_variant[3:1] == VAR_LAYOUT_8 && r0[4]);
    return r;
  endfunction

  function automatic res_t predicted_result(logic [1:0] op, logic [15:0] addr,
                                            logic [7:0] val, logic [7:0] mode,
                                            logic [7:0] ib0, logic [7:0] ib1,
                                            logic [7:0] ib2);
    res_t r;
    r = '0;
    case (op)
      OP_CPU_WRITE: r = cpu_write_outcome(addr, val);
      OP_PRG_QUERY: r.bank = prg_bank_of(addr, val, mode, ib0, ib2);
      OP_CHR_QUERY: r = chr_lookup(addr, val, mode, ib0, ib1);
      default:      r = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got, want;
    if (rst) begin
      oregs = '0;
      cfg.window_at_5000 = 1'b0;
      cfg.board_variant = 4'd0;
      cfg.prg_half_banks = PRG_HALF_BANKS_RST;
      cfg.chr_ram_present = 1'b0;
      expected_results.delete();
      fail_total = 0;
    end else begin
      if (res_valid && !res_stall) begin
        got.bank = bank;
        got.use_chr_ram = use_chr_ram;
        got.chr_write_enable = chr_write_enable;
        got.forward_to_inner = forward_to_inner;
        got.register_written = register_written;
        if (expected_results.size() == 0) begin
          fail_total++;
          $display("%0t: result with no request pending: bank=%03h ram=%b we=%b fwd=%b wr=%b",
                   $time, got.bank, got.use_chr_ram, got.chr_write_enable,
                   got.forward_to_inner, got.register_written);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_total++;
            $display("%0t: mismatch: expected bank=%03h ram=%b we=%b fwd=%b wr=%b",
                     $time, want.bank, want.use_chr_ram, want.chr_write_enable,
                     want.forward_to_inner, want.register_written);
            $display("%0t:           actual bank=%03h ram=%b we=%b fwd=%b wr=%b",
                     $time, got.bank, got.use_chr_ram, got.chr_write_enable,
                     got.forward_to_inner, got.register_written);
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_WINDOW_AT_5000:  cfg.window_at_5000 = cfg_data[0];
          CFG_BOARD_VARIANT:   cfg.board_variant = cfg_data[3:0];
          CFG_PRG_HALF_BANKS:  cfg.prg_half_banks = cfg_data;
          CFG_CHR_RAM_PRESENT: cfg.chr_ram_present = cfg_data[0];
          default: ;
        endcase
      end
      if (req_valid && !req_stall)
        expected_results.push_back(predicted_result(operation, address, value, inner_mode,
                                                     inner_bank0, inner_bank1, inner_bank2));
    end
    mismatches <= fail_total;
    outstanding <= expected_results.size();
  end

endmodule

FILE: tb/sv/multicart_outer_bank_mapper_test.sv
`timescale 1ns / 100ps
// stimulus and verdict for the multicart outer bank mapper

module multicart_outer_bank_mapper_test;
  import mcobm_pkg::*;

  // the block passes this code through as a no-op
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  operation = OP_CPU_WRITE;
  logic [15:0] address = '0;
  logic [7:0]  value = '0;
  logic [7:0]  inner_mode = '0;
  logic [7:0]  inner_bank0 = '0;
  logic [7:0]  inner_bank1 = '0;
  logic [7:0]  inner_bank2 = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [11:0] bank;
  logic        use_chr_ram;
  logic        chr_write_enable;
  logic        forward_to_inner;
  logic        register_written;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = CFG_WINDOW_AT_5000;
  logic [11:0] cfg_data = '0;

  int unsigned mismatches;
  int unsigned outstanding;

  // idling percentages, read by the sender and the receiver each cycle
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  // long receiver hold-off, counted down in the receiver process
  int unsigned hold_len = 0;
  // current register window, so most writes can be aimed at it
  logic        cur_window = 1'b0;

  always #5 clk = ~clk;

  multicart_outer_bank_mapper uut (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .operation        (operation),
    .address          (address),
    .value            (value),
    .inner_mode       (inner_mode),
    .inner_bank0      (inner_bank0),
    .inner_bank1      (inner_bank1),
    .inner_bank2      (inner_bank2),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .bank             (bank),
    .use_chr_ram      (use_chr_ram),
    .chr_write_enable (chr_write_enable),
    .forward_to_inner (forward_to_inner),
    .register_written (register_written),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  multicart_outer_bank_mapper_checker result_check (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .operation        (operation),
    .address          (address),
    .value            (value),
    .inner_mode       (inner_mode),
    .inner_bank0      (inner_bank0),
    .inner_bank1      (inner_bank1),
    .inner_bank2      (inner_bank2),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .bank             (bank),
    .use_chr_ram      (use_chr_ram),
    .chr_write_enable (chr_write_enable),
    .forward_to_inner (forward_to_inner),
    .register_written (register_written),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  // all four configuration registers, one write per cycle, block idle
  task automatic set_config(logic w, logic [3:0] v, logic [11:0] phb, logic crp);
    cfg_write <= 1'b1;
    cfg_index <= CFG_WINDOW_AT_5000;
    cfg_data  <= {11'd0, w};
    @(posedge clk);
    cfg_index <= CFG_BOARD_VARIANT;
    cfg_data  <= {8'd0, v};
    @(posedge clk);
    cfg_index <= CFG_PRG_HALF_BANKS;
    cfg_data  <= phb;
    @(posedge clk);
    cfg_index <= CFG_CHR_RAM_PRESENT;
    cfg_data  <= {11'd0, crp};
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    cur_window = w;
  endtask

  // offer one request, with random idle cycles in front, and wait for it to go in
  task automatic offer_request(logic [1:0] op, logic [15:0] addr, logic [7:0] val,
                               logic [7:0] mode, logic [7:0] b0, logic [7:0] b1,
                               logic [7:0] b2);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    operation   <= op;
    address     <= addr;
    value       <= val;
    inner_mode  <= mode;
    inner_bank0 <= b0;
    inner_bank1 <= b1;
    inner_bank2 <= b2;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // small set of values so that chr queries often match the ram tag in reg 4
  function automatic logic [7:0] ram_tag();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'hA4;
      default: return 8'hA5;
    endcase
  endfunction

  // mostly well-aimed requests: window writes, slot-aligned queries, plus noise
  task automatic run_random(int count, bit allow_lock);
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  val;
    int unsigned pick;
    int unsigned sel;
    repeat (count) begin
      pick = $urandom_range(99);
      sel = $urandom_range(99);
      addr = 16'($urandom);
      val = 8'($urandom);
      if (pick < 38) begin
        op = OP_CPU_WRITE;
        if (sel < 75) begin
          if (cur_window) addr = 16'h5000 + 16'($urandom_range(16'h0FFF));
          else addr = 16'h6000 + 16'($urandom_range(16'h1FFF));
        end else if (sel < 90) begin
          addr[15] = 1'b1;
        end
        if ($urandom_range(99) < 30) val = ram_tag();
        // the lock cannot be undone without a reset, so it waits for the last phase
        if (addr[2:0] == OREG_CONTROL && !allow_lock) val[7] = 1'b0;
      end else if (pick < 70) begin
        op = OP_PRG_QUERY;
        if (sel < 60) addr = {1'b1, 2'($urandom), 13'd0};
      end else if (pick < 97) begin
        op = OP_CHR_QUERY;
        if (sel < 60) addr = {3'd0, 3'($urandom), 10'd0};
        if ($urandom_range(99) < 40) val = ram_tag();
      end else begin
        op = OP_UNKNOWN;
      end
      offer_request(op, addr, val, 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
    end
  endtask

  // stop offering and wait until every result is back, then a short settle
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(int unsigned send_idle, int unsigned recv_stall);
    idle_pct = send_idle;
    stall_pct = recv_stall;
  endtask

  // receiver: random stalls, or a long hold-off when one is asked for
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        res_stall <= 1'b1;
        repeat (hold_len - 1) @(posedge clk);
        hold_len = 0;
      end else begin
        res_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default window, default layout, chr ram on, no idling
    set_config(1'b0, 4'd0, 12'd64, 1'b1);
    set_idling(0, 0);
    // window edges, outside the window, forwarding to the inner mapper
    offer_request(OP_CPU_WRITE, 16'h6000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_request(OP_CPU_WRITE, 16'h7FFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_request(OP_CPU_WRITE, 16'h5FFF, 8'h12, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_request(OP_CPU_WRITE, 16'hFFFF, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00);
    // chr outer register: full write, then a write under its own partial lock
    offer_request(OP_CPU_WRITE, 16'h6002, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_request(OP_CPU_WRITE, 16'h6002, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_request(OP_CPU_WRITE, 16'h6004, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_request(OP_PRG_QUERY, 16'h8000, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
    // fixed-slot mode: the two top slots, an ordinary slot, the blocking inner mode
    offer_request(OP_CPU_WRITE, 16'h6003, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_request(OP_PRG_QUERY, 16'hC000, 8'h5A, 8'h00, 8'hFF, 8'h00, 8'hFF);
    offer_request(OP_PRG_QUERY, 16'hE000, 8'h5A, 8'h00, 8'hFF, 8'h00, 8'hFF);
    offer_request(OP_PRG_QUERY, 16'hA000, 8'h5A, 8'h00, 8'hFF, 8'h00, 8'hFF);
    offer_request(OP_PRG_QUERY, 16'hC000, 8'h5A, 8'h40, 8'hFF, 8'h00, 8'hFF);
    // chr in fixed mode: inner bank substitution with the half swap, zeroed slot
    offer_request(OP_CHR_QUERY, 16'h1000, 8'h33, 8'h80, 8'h5A, 8'hA5, 8'h00);
    offer_request(OP_CHR_QUERY, 16'h0C00, 8'hFF, 8'h00, 8'h5A, 8'hA5, 8'h00);
    offer_request(OP_CPU_WRITE, 16'h6003, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_request(OP_CHR_QUERY, 16'h1C00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_request(OP_UNKNOWN,   16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_random(100, 1'b0);
    drain();

    // 0x5000 window, layout 2, no chr ram, sender idling
    set_config(1'b1, 4'd2, 12'd64, 1'b0);
    set_idling(79, 0);
    offer_request(OP_CPU_WRITE, 16'h5000, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_request(OP_CPU_WRITE, 16'h4FFF, 8'h11, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_request(OP_CPU_WRITE, 16'h8000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    run_random(120, 1'b0);
    drain();

    // layout 4 with a prg size of 1, receiver stalling
    set_config(1'b0, 4'd4, 12'd1, 1'b1);
    set_idling(0, 79);
    run_random(120, 1'b0);
    drain();

    // layout 6 with a prg size of 2048, both sides idling
    set_config(1'b1, 4'd6, 12'd2048, 1'b1);
    set_idling(26, 26);
    run_random(120, 1'b0);
    drain();

    // odd variant number on layout 6, non-power-of-two size; long hold-off so the
    // result register and the input register both fill and the request side stalls
    set_config(1'b0, 4'd7, 12'd3, 1'b1);
    set_idling(0, 0);
    hold_len = 48;
    run_random(120, 1'b0);
    drain();

    // layout 8 with a zero prg size
    set_config(1'b0, 4'd8, 12'd0, 1'b1);
    set_idling(26, 26);
    run_random(120, 1'b0);
    drain();

    // highest variant number and all-ones size
    set_config(1'b1, 4'd15, 12'hFFF, 1'b0);
    set_idling(79, 0);
    run_random(100, 1'b0);
    drain();

    set_config(1'b0, 4'd6, 12'd16, 1'b1);
    set_idling(0, 79);
    run_random(100, 1'b0);
    drain();

    // last phase: set the lock, which stays for the rest of the run
    set_config(1'b0, 4'd9, 12'd512, 1'b1);
    set_idling(26, 26);
    offer_request(OP_CPU_WRITE, 16'h6003, 8'h90, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_request(OP_CPU_WRITE, 16'h6000, 8'h55, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_request(OP_CPU_WRITE, 16'h6002, 8'h3C, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_request(OP_CHR_QUERY, 16'h0800, 8'h77, 8'h00, 8'h11, 8'h33, 8'h00);
    offer_request(OP_PRG_QUERY, 16'hE000, 8'hC3, 8'h80, 8'h00, 8'h00, 8'h80);
    run_random(50, 1'b1);
    drain();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
